>>> sv/gee_pkg.sv
// Shared types and constants for the graph eccentricity engine.
`timescale 1ns / 1ps

package gee_pkg;

	// Width of the vertex count register and of the vertex and distance fields.
	localparam int CNT_W   = 7;
	localparam int FIELD_W = 6;

	// Vertex count after reset.
	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

	// Command codes carried on the cmd port.
	typedef enum logic [1:0] {
		CMD_ADD_EDGE = 2'd0,
		CMD_RUN      = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	// Edge insertion request toward the adjacency store.
	typedef struct packed {
		logic               valid;
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
	} edge_req_t;

	// Row read request from the walk sequencer.
	typedef struct packed {
		logic               en;
		logic [FIELD_W-1:0] row;
	} rd_req_t;

	// One result beat.
	typedef struct packed {
		logic               valid;
		logic [FIELD_W-1:0] source_vertex;
		logic [FIELD_W-1:0] eccentricity;
		logic [FIELD_W-1:0] farthest_vertex;
		logic               farthest_valid;
		logic               last;
	} result_t;

endpackage

>>> sv/gee_adj_mem.sv
// Adjacency matrix store with row valid bits and edge read-modify-write.
`timescale 1ns / 1ps

module gee_adj_mem import gee_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  edge_req_t               edge_req,
	input  logic                    clear,
	input  rd_req_t                 rd_req,
	output logic [MAX_VERTICES-1:0] row_data
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] rdata_q;
	logic                    rok_s1;
	logic [MAX_VERTICES-1:0] row_valid_q;

	logic                    e_v_s1;
	logic [VW-1:0]           e_row_s1;
	logic [VW-1:0]           e_col_s1;

	logic                    fwd_v_q;
	logic [VW-1:0]           fwd_row_q;
	logic [MAX_VERTICES-1:0] fwd_data_q;

	logic                    rd_en;
	logic [VW-1:0]           rd_row;
	logic [MAX_VERTICES-1:0] base;
	logic [MAX_VERTICES-1:0] wr_data;

	// Edge reads and walk reads never occur in the same cycle.
	assign rd_en  = edge_req.valid | rd_req.en;
	assign rd_row = edge_req.valid ? edge_req.row[VW-1:0] : rd_req.row[VW-1:0];

	// The row that was written in the cycle of this read is taken from the bypass.
	always_comb begin
		if (fwd_v_q && (fwd_row_q == e_row_s1)) begin
			base = fwd_data_q;
		end else begin
			base = rok_s1 ? rdata_q : '0;
		end
		wr_data = base | (ONE << e_col_s1);
	end

	assign row_data = rok_s1 ? rdata_q : '0;

	// Memory write port.
	always_ff @(posedge clk) begin
		if (e_v_s1) begin
			mem[e_row_s1] <= wr_data;
		end
	end

	// Memory read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_row];
		end
	end

	// Edge pipeline payload and bypass data.
	always_ff @(posedge clk) begin
		e_row_s1   <= edge_req.row[VW-1:0];
		e_col_s1   <= edge_req.col[VW-1:0];
		fwd_row_q  <= e_row_s1;
		fwd_data_q <= wr_data;
	end

	// Control state: row valid bits, read qualifier and write tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rok_s1      <= 1'b0;
			e_v_s1      <= 1'b0;
			fwd_v_q     <= 1'b0;
		end else begin
			e_v_s1 <= edge_req.valid;
			if (rd_en) begin
				rok_s1 <= row_valid_q[rd_row];
			end
			// A clear wipes a write that lands in the same cycle.
			if (clear) begin
				row_valid_q <= '0;
				fwd_v_q     <= 1'b0;
			end else begin
				fwd_v_q <= e_v_s1;
				if (e_v_s1) begin
					row_valid_q[e_row_s1] <= 1'b1;
				end
			end
		end
	end

endmodule

>>> sv/gee_walk.sv
// Breadth-first walk sequencer that produces one eccentricity result per source.
`timescale 1ns / 1ps

module gee_walk import gee_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    run_start,
	input  logic [CNT_W-1:0]        vertex_count,
	input  logic [MAX_VERTICES-1:0] row_data,
	output rd_req_t                 rd_req,
	output logic                    busy,
	output result_t                 res
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t                  state_q;
	logic [VW-1:0]           src_q;
	logic [CW-1:0]           n_q;
	logic [MAX_VERTICES-1:0] vmask_q;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] pend_q;
	logic [MAX_VERTICES-1:0] next_q;
	logic                    rd_pend_s1;
	logic [FIELD_W-1:0]      dist_q;
	logic [VW-1:0]           far_q;
	result_t                 res_q;

	logic [CW-1:0]           n_c;
	logic [MAX_VERTICES-1:0] vmask_c;
	logic [VW-1:0]           pick;
	logic [MAX_VERTICES-1:0] acc;
	logic [MAX_VERTICES-1:0] nxt;
	logic                    level_done;
	logic [CW-1:0]           src_plus;
	logic                    is_last;

	// Index of the lowest set bit.
	function automatic logic [VW-1:0] low_index(input logic [MAX_VERTICES-1:0] m);
		logic [VW-1:0] idx;
		idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = VW'(i);
			end
		end
		return idx;
	endfunction

	// Clamp the vertex count into range and build the mask of vertices in use.
	always_comb begin
		if (vertex_count == '0) begin
			n_c = CW'(1);
		end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
			n_c = CW'(MAX_VERTICES);
		end else begin
			n_c = CW'(vertex_count);
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask_c[i] = (CW'(i) < n_c);
		end
	end

	// Frontier scan, level accumulation and end of level detection.
	assign pick       = low_index(pend_q);
	assign acc        = next_q | (rd_pend_s1 ? row_data : '0);
	assign nxt        = next_q & vmask_q & ~reached_q;
	assign level_done = (state_q == ST_WALK) && (pend_q == '0) && !rd_pend_s1;
	assign src_plus   = CW'(src_q) + CW'(1);
	assign is_last    = (src_plus == n_q);

	assign rd_req.en  = (state_q == ST_WALK) && (pend_q != '0);
	assign rd_req.row = FIELD_W'(pick);
	assign busy       = (state_q != ST_IDLE);
	assign res        = res_q;

	// Walk datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (run_start) begin
					n_q       <= n_c;
					vmask_q   <= vmask_c;
					src_q     <= '0;
					reached_q <= ONE;
					pend_q    <= ONE;
					next_q    <= '0;
					dist_q    <= '0;
					far_q     <= '0;
				end
			end
			ST_WALK: begin
				if (level_done) begin
					next_q <= '0;
					if (nxt == '0) begin
						// Start over from the next source.
						src_q     <= src_plus[VW-1:0];
						reached_q <= ONE << src_plus[VW-1:0];
						pend_q    <= ONE << src_plus[VW-1:0];
						dist_q    <= '0;
						far_q     <= '0;
					end else begin
						dist_q    <= dist_q + FIELD_W'(1);
						far_q     <= low_index(nxt);
						reached_q <= reached_q | nxt;
						pend_q    <= nxt;
					end
				end else begin
					next_q <= acc;
					if (pend_q != '0) begin
						pend_q <= pend_q & ~(ONE << pick);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control: state, read tracking and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_pend_s1 <= 1'b0;
			res_q      <= '0;
		end else begin
			rd_pend_s1  <= rd_req.en;
			res_q.valid <= level_done && (nxt == '0);
			// The result payload is captured when a source finishes.
			if (level_done && (nxt == '0)) begin
				res_q.source_vertex   <= FIELD_W'(src_q);
				res_q.eccentricity    <= dist_q;
				res_q.farthest_vertex <= FIELD_W'(far_q);
				res_q.farthest_valid  <= (dist_q != '0);
				res_q.last            <= is_last;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (run_start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (level_done && (nxt == '0) && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/graph_eccentricity_engine.sv
// Top level of the graph eccentricity engine: command decode, register and result ports.
//
// Channel   Direction  Handshake                    Beat
// command   in         start && !busy               cmd, from_vertex, to_vertex
// config    in         cfg_valid && cfg_ready       cfg_data (vertex_count)
// result    out        result_valid, one cycle      source_vertex .. last
//
// Add-edge, clear and unused commands may follow back to back.
// A run holds busy high while the levels are walked; the single read port of the
// adjacency memory delivers one row per cycle, and the walk from a source ends at
// its first level that finds no new vertex. Reset clears the row valid bits at once,
// so no clearing pass is needed. Results are shown for one cycle each; the receiver
// cannot stall them.
`timescale 1ns / 1ps

module graph_eccentricity_engine import gee_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [FIELD_W-1:0] from_vertex,
	input  logic [FIELD_W-1:0] to_vertex,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [FIELD_W-1:0] source_vertex,
	output logic [FIELD_W-1:0] eccentricity,
	output logic [FIELD_W-1:0] farthest_vertex,
	output logic               farthest_valid,
	output logic               last
);

	logic [CNT_W-1:0]        vertex_count_q;
	logic                    accept;
	cmd_t                    cmd_in;
	edge_req_t               edge_req;
	logic                    clear;
	logic                    run_start;
	rd_req_t                 rd_req;
	logic [MAX_VERTICES-1:0] row_data;
	result_t                 res;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cmd_in    = cmd_t'(cmd);

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	// Command decode for an accepted beat.
	always_comb begin
		edge_req.valid = 1'b0;
		edge_req.row   = from_vertex;
		edge_req.col   = to_vertex;
		clear          = 1'b0;
		run_start      = 1'b0;
		if (accept) begin
			unique case (cmd_in)
				CMD_ADD_EDGE: begin
					edge_req.valid = ({1'b0, from_vertex} < CNT_W'(MAX_VERTICES)) &&
					                 ({1'b0, to_vertex} < CNT_W'(MAX_VERTICES));
				end
				CMD_RUN: begin
					run_start = 1'b1;
				end
				CMD_CLEAR: begin
					clear = 1'b1;
				end
				CMD_NONE: begin
				end
			endcase
		end
	end

	gee_adj_mem #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.edge_req (edge_req),
		.clear    (clear),
		.rd_req   (rd_req),
		.row_data (row_data)
	);

	gee_walk #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_start    (run_start),
		.vertex_count (vertex_count_q),
		.row_data     (row_data),
		.rd_req       (rd_req),
		.busy         (busy),
		.res          (res)
	);

	// Result ports.
	assign result_valid    = res.valid;
	assign source_vertex   = res.source_vertex;
	assign eccentricity    = res.eccentricity;
	assign farthest_vertex = res.farthest_vertex;
	assign farthest_valid  = res.farthest_valid;
	assign last            = res.last;

endmodule

>>> tb/ecc_checker.sv
// Checker for the graph eccentricity engine: tracks the graph, predicts run results, compares beats.
`timescale 1ns / 1ps

module ecc_checker import gee_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         cmd,
	input  logic [FIELD_W-1:0] from_vertex,
	input  logic [FIELD_W-1:0] to_vertex,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               result_valid,
	input  logic [FIELD_W-1:0] source_vertex,
	input  logic [FIELD_W-1:0] eccentricity,
	input  logic [FIELD_W-1:0] farthest_vertex,
	input  logic               farthest_valid,
	input  logic               last,
	output int                 mismatches,
	output int                 outstanding
);

	// One expected result beat.
	typedef struct packed {
		logic [FIELD_W-1:0] src;
		logic [FIELD_W-1:0] ecc;
		logic [FIELD_W-1:0] far;
		logic               far_ok;
		logic               last;
	} ecc_beat_t;

	// Shadow copy of the adjacency matrix and the vertex count register.
	logic [63:0]      adj_rows [64];
	logic [CNT_W-1:0] vcount;
	ecc_beat_t        ecc_expected [$];
	ecc_beat_t        want;

	// Breadth-first walk from every active source; queues one beat per source.
	function automatic void walk_all_sources();
		int          n;
		int          hops;
		int          far;
		logic [63:0] in_use;
		logic [63:0] seen;
		logic [63:0] level;
		logic [63:0] nxt;
		ecc_beat_t   beat;
		// A count of zero acts as one, anything above 64 acts as 64.
		n = (vcount == 0) ? 1 : (vcount > 64) ? 64 : int'(vcount);
		in_use = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
		for (int s = 0; s < n; s++) begin
			seen = 64'd1 << s;
			level = seen;
			hops = 0;
			far = 0;
			while (1) begin
				nxt = '0;
				for (int v = 0; v < n; v++) begin
					if (level[v])
						nxt |= adj_rows[v];
				end
				// The source itself and inactive vertices never count as reached.
				nxt &= in_use & ~seen;
				if (nxt == '0)
					break;
				hops++;
				for (int b = 63; b >= 0; b--) begin
					if (nxt[b])
						far = b;
				end
				seen |= nxt;
				level = nxt;
			end
			beat.src = FIELD_W'(s);
			beat.ecc = FIELD_W'(hops);
			beat.far = FIELD_W'(far);
			beat.far_ok = (hops > 0);
			beat.last = (s == n - 1);
			ecc_expected = {ecc_expected, beat};
		end
	endfunction

	function automatic void check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch for source %0d: expected %0d, actual %0d",
				$time, name, want.src, exp_val, got_val);
			mismatches++;
		end
	endfunction

	// Compare result beats, then track register writes and accepted commands.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 64; r++)
				adj_rows[r] = '0;
			vcount = VCOUNT_RESET;
			ecc_expected.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				if (ecc_expected.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, actual source %0d",
						$time, source_vertex);
					mismatches++;
				end else begin
					want = ecc_expected.pop_front();
					check_field("source_vertex", int'(want.src), int'(source_vertex));
					check_field("eccentricity", int'(want.ecc), int'(eccentricity));
					check_field("farthest_vertex", int'(want.far), int'(farthest_vertex));
					check_field("farthest_valid", int'(want.far_ok), int'(farthest_valid));
					check_field("last", int'(want.last), int'(last));
				end
			end
			if (cfg_valid && cfg_ready)
				vcount = cfg_data;
			if (start && !busy) begin
				case (cmd_t'(cmd))
					CMD_ADD_EDGE: begin
						adj_rows[from_vertex][to_vertex] = 1'b1;
					end
					CMD_CLEAR: begin
						for (int r = 0; r < 64; r++)
							adj_rows[r] = '0;
					end
					CMD_RUN: begin
						walk_all_sources();
					end
					default: begin
					end
				endcase
			end
			outstanding <= ecc_expected.size();
		end
	end

endmodule

>>> tb/graph_eccentricity_engine_tb.sv
// Testbench top for the graph eccentricity engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module graph_eccentricity_engine_tb;
	import gee_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [FIELD_W-1:0] from_vertex;
	logic [FIELD_W-1:0] to_vertex;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;
	logic               result_valid;
	logic [FIELD_W-1:0] source_vertex;
	logic [FIELD_W-1:0] eccentricity;
	logic [FIELD_W-1:0] farthest_vertex;
	logic               farthest_valid;
	logic               last;
	int                 mismatches;
	int                 outstanding;

	graph_eccentricity_engine u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.source_vertex   (source_vertex),
		.eccentricity    (eccentricity),
		.farthest_vertex (farthest_vertex),
		.farthest_valid  (farthest_valid),
		.last            (last)
	);

	ecc_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.source_vertex   (source_vertex),
		.eccentricity    (eccentricity),
		.farthest_vertex (farthest_vertex),
		.farthest_valid  (farthest_valid),
		.last            (last),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the engine hangs.
	initial begin
		#250_000_000;
		$display("tb: failure");
		$finish;
	end

	// Present one command beat and hold it until the engine takes it.
	task automatic issue(input cmd_t op, input int tail, input int head);
		start <= 1'b1;
		cmd <= op;
		from_vertex <= FIELD_W'(tail);
		to_vertex <= FIELD_W'(head);
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic pause_input(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait until every expected beat has arrived and the engine is idle.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		cfg_data <= CNT_W'(value);
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed cases first, then random phases at varied vertex counts.
	initial begin
		int sent;
		int phase_len;
		int count;
		int n_eff;
		int pick;
		bit gaps;
		bit quiet;

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_ADD_EDGE;
		from_vertex <= '0;
		to_vertex <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Empty graph at the reset count of 64, then the corner vertices.
		issue(CMD_RUN, 0, 0);
		issue(CMD_ADD_EDGE, 0, 63);
		issue(CMD_ADD_EDGE, 63, 0);
		issue(CMD_ADD_EDGE, 0, 63);
		issue(CMD_ADD_EDGE, 5, 5);
		issue(CMD_RUN, 0, 0);
		issue(CMD_NONE, 63, 63);
		issue(CMD_CLEAR, 0, 0);
		issue(CMD_RUN, 0, 0);
		drain();

		// Four vertices: a cycle back to the source, ties at the far level,
		// and edges through a vertex beyond the count.
		write_count(4);
		issue(CMD_ADD_EDGE, 0, 1);
		issue(CMD_ADD_EDGE, 0, 2);
		issue(CMD_ADD_EDGE, 2, 3);
		issue(CMD_ADD_EDGE, 1, 3);
		issue(CMD_ADD_EDGE, 3, 0);
		issue(CMD_ADD_EDGE, 0, 10);
		issue(CMD_ADD_EDGE, 10, 2);
		issue(CMD_RUN, 0, 0);
		drain();

		// A count of zero acts as one vertex; an oversized count acts as 64.
		write_count(0);
		issue(CMD_RUN, 0, 0);
		drain();
		write_count(127);
		issue(CMD_ADD_EDGE, 42, 21);
		issue(CMD_RUN, 0, 0);
		drain();

		// Random phases: mostly in-range edges so runs see deep walks.
		sent = 0;
		quiet = 1'b0;
		while (sent < 310) begin
			pick = $urandom_range(0, 11);
			if (pick < 2)
				count = 64;
			else if (pick == 2)
				count = $urandom_range(0, 1);
			else if (pick == 3)
				count = $urandom_range(65, 127);
			else
				count = $urandom_range(2, 12);
			n_eff = (count == 0) ? 1 : (count > 64) ? 64 : count;
			drain();
			write_count(count);
			gaps = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(6, 30);
			if ($urandom_range(0, 2) == 0) begin
				issue(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
				sent++;
			end
			for (int k = 0; k < phase_len; k++) begin
				quiet = (sent >= 280);
				if (gaps && !quiet && $urandom_range(0, 2) == 0)
					pause_input($urandom_range(1, 5));
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					issue(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
					sent++;
				end else if (pick < 7) begin
					issue(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
				end else if (pick < 17) begin
					issue(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
					sent++;
				end else if (pick < 90) begin
					issue(CMD_ADD_EDGE, $urandom_range(0, n_eff - 1),
						$urandom_range(0, n_eff - 1));
					sent++;
				end else begin
					issue(CMD_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63));
					sent++;
				end
			end
			issue(CMD_RUN, 0, 0);
			sent++;
		end

		// Let the last run finish, then settle.
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
sv/gee_pkg.sv
sv/gee_adj_mem.sv
sv/gee_walk.sv
sv/graph_eccentricity_engine.sv
tb/ecc_checker.sv
tb/graph_eccentricity_engine_tb.sv
